@@ sv/ilc_pkg.sv @@
// ----------------------------------------------------------------------------
// ilc_pkg
// Types, constants and parse and classify functions shared by the literal classifier.
// ----------------------------------------------------------------------------
package ilc_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDot   = 8'h2E;

  typedef enum logic [2:0] {
    PH_START     = 3'd0,
    PH_LEAD      = 3'd1,
    PH_AFTER_RUN = 3'd2,
    PH_TOKEN     = 3'd3,
    PH_QUAD      = 3'd4,
    PH_SEP       = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    CLS_PUBLIC    = 3'd0,
    CLS_PRIVATE   = 3'd1,
    CLS_LOOPBACK  = 3'd2,
    CLS_LINKLOCAL = 3'd3,
    CLS_UNKNOWN   = 3'd4
  } class_e;

  typedef enum logic [1:0] {
    FORM_NONE = 2'd0,
    FORM_V4   = 2'd1,
    FORM_V6   = 2'd2
  } form_e;

  typedef struct packed {
    logic [3:0][7:0] octets;
    logic [9:0]      accum;
    logic [1:0]      idx;
    logic [1:0]      dig;
    logic            failed;
  } v4_t;

  typedef struct packed {
    logic [7:0][15:0] head;
    logic [7:0][15:0] tail;
    logic [3:0]       hc;
    logic [3:0]       tc;
    logic             run;
    logic [3:0][7:0]  tok;
    logic [2:0]       tlen;
    phase_e           phase;
    logic             failed;
  } v6_t;

  // One finished literal, handed from the parser to the classifier.
  typedef struct packed {
    form_e            form;
    logic [31:0]      v4_addr;
    logic [7:0][15:0] head;
    logic [7:0][15:0] tail;
    logic [3:0]       hc;
    logic [3:0]       tc;
  } entry_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return is_dec(c) ? c[3:0] : 4'(c[3:0] + 4'd9);
  endfunction

  function automatic v4_t v4_feed(input v4_t s, input logic [7:0] c);
    v4_t r;
    r = s;
    if (!s.failed) begin
      if (is_dec(c)) begin
        if (s.dig == 2'd3 || (s.dig == 2'd1 && s.accum == 10'd0)) begin
          r.failed = 1'b1;
        end else begin
          r.accum = 10'(s.accum * 10'd10 + {6'd0, c[3:0]});
          r.dig   = 2'(s.dig + 2'd1);
        end
      end else if (c == ChDot) begin
        if (s.dig == 2'd0 || s.accum > 10'd255 || s.idx == 2'd3) begin
          r.failed = 1'b1;
        end else begin
          r.octets[s.idx] = s.accum[7:0];
          r.idx   = 2'(s.idx + 2'd1);
          r.dig   = 2'd0;
          r.accum = 10'd0;
        end
      end else begin
        r.failed = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic v4_done(input v4_t s);
    return !s.failed && s.dig != 2'd0 && s.accum <= 10'd255 && s.idx == 2'd3;
  endfunction

  function automatic v6_t v6_push(input v6_t s, input logic [15:0] g, output logic ok);
    v6_t r;
    r  = s;
    ok = 1'b1;
    if (s.run) begin
      if (s.tc >= 4'd8) ok = 1'b0;
      else begin
        r.tail[s.tc[2:0]] = g;
        r.tc = 4'(s.tc + 4'd1);
      end
    end else begin
      if (s.hc >= 4'd8) ok = 1'b0;
      else begin
        r.head[s.hc[2:0]] = g;
        r.hc = 4'(s.hc + 4'd1);
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] tok_value(input v6_t s);
    logic [15:0] v;
    v = 16'd0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < s.tlen) v = {v[11:0], hex_val(s.tok[i])};
    end
    return v;
  endfunction

  function automatic logic v6_finish(input v6_t s);
    logic [4:0] total;
    total = {1'b0, s.hc} + {1'b0, s.tc};
    return s.run ? (total < 5'd8) : (total == 5'd8);
  endfunction

  function automatic class_e classify_v4(input logic [7:0] o0, input logic [7:0] o1);
    class_e c;
    if (o0 == 8'd0) c = CLS_UNKNOWN;
    else if (o0 == 8'd127) c = CLS_LOOPBACK;
    else if (o0 >= 8'd224) c = CLS_UNKNOWN;
    else if (o0 == 8'd169) c = (o1 == 8'd254) ? CLS_LINKLOCAL : CLS_PUBLIC;
    else if (o0 == 8'd10 || (o0 == 8'd172 && o1 >= 8'd16 && o1 <= 8'd31) ||
             (o0 == 8'd192 && o1 == 8'd168) ||
             (o0 == 8'd100 && o1 >= 8'd64 && o1 <= 8'd127)) c = CLS_PRIVATE;
    else c = CLS_PUBLIC;
    return c;
  endfunction

  function automatic class_e classify_v6(input logic [63:0] hi, input logic [63:0] lo);
    class_e c;
    if (hi == 64'd0 && lo[63:32] == 32'h0000_FFFF) c = classify_v4(lo[31:24], lo[23:16]);
    else if (hi == 64'd0 && lo == 64'd1) c = CLS_LOOPBACK;
    else if (hi == 64'd0 && lo == 64'd0) c = CLS_UNKNOWN;
    else if (hi[63:56] == 8'hFF) c = CLS_UNKNOWN;
    else if (hi[63:56] == 8'hFE && (hi[55:48] & 8'hC0) == 8'h80) c = CLS_LINKLOCAL;
    else if ((hi[63:56] & 8'hFE) == 8'hFC) c = CLS_PRIVATE;
    else c = CLS_PUBLIC;
    return c;
  endfunction

endpackage

@@ sv/ilc_in_if.sv @@
// ----------------------------------------------------------------------------
// ilc_in_if
// Character channel: one literal byte or an end marker per transfer.
// ----------------------------------------------------------------------------
interface ilc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;

  modport source (output valid, output kind, output char_code, input ready);
  modport sink (input valid, input kind, input char_code, output ready);
endinterface

@@ sv/ilc_out_if.sv @@
// ----------------------------------------------------------------------------
// ilc_out_if
// Result channel: one classified address per transfer.
// ----------------------------------------------------------------------------
interface ilc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr_class;
  logic        fetchable;
  logic [1:0]  literal_form;
  logic [63:0] addr_hi;
  logic [63:0] addr_lo;

  modport source (output valid, output addr_class, output fetchable, output literal_form,
                  output addr_hi, output addr_lo, input ready);
  modport sink (input valid, input addr_class, input fetchable, input literal_form,
                input addr_hi, input addr_lo, output ready);
endinterface

@@ sv/ip_literal_classifier.sv @@
// ----------------------------------------------------------------------------
// ip_literal_classifier
// Address literal parser and classifier for IPv4 and IPv6 literals.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake     Payload
// lit_i     in   valid/ready   kind, char_code
// res_o     out  valid/ready   addr_class, fetchable, literal_form, addr_hi, addr_lo
// cfg       in   cfg_we_i      cfg_wdata_i (private ranges fetchable)
//
// One character is taken in every cycle unless the queue is full; the parser
// state is registered. An end marker enters the queue, and its result is loaded
// into the output register as soon as the classifier stage is free.
// The character channel stalls only when the queue of finished literals is full.
// Reset clears the parser, the queue, the output valid and the private-range setting.
// ----------------------------------------------------------------------------
module ip_literal_classifier import ilc_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ilc_in_if.sink    lit_i,
  ilc_out_if.source res_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  logic   allow_q;
  logic   q_ready, q_push, q_valid, q_pop;
  entry_t push_entry, pop_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_q <= 1'b0;
    end else if (cfg_we_i) begin
      allow_q <= cfg_wdata_i;
    end
  end

  ilc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .lit_i     (lit_i),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_entry_o (push_entry)
  );

  ilc_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (pop_entry)
  );

  ilc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .priv_fetch_i (allow_q),
    .q_valid_i    (q_valid),
    .q_entry_i    (pop_entry),
    .q_pop_o      (q_pop),
    .res_o        (res_o)
  );

endmodule

@@ sv/ilc_front.sv @@
// ----------------------------------------------------------------------------
// ilc_front
// Character parser: runs the IPv4 and IPv6 parsers side by side and, at the
// end marker, hands the finished parse to the queue.
// ----------------------------------------------------------------------------
module ilc_front import ilc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  ilc_in_if.sink   lit_i,
  input  logic     q_ready_i,
  output logic     q_push_o,
  output entry_t   q_entry_o
);

  v4_t  v4_q, v4_d;
  v6_t  v6_q, v6_d;
  logic seen_q, seen_d;
  logic acc;

  assign lit_i.ready = q_ready_i;
  assign acc         = lit_i.valid && lit_i.ready;
  assign q_push_o    = acc && lit_i.kind;

  // Per-character update.
  always_comb begin
    logic [7:0] c;
    logic       do_tok;
    logic       ok;
    v6_t        t;
    c      = lit_i.char_code;
    v4_d   = v4_q;
    v6_d   = v6_q;
    seen_d = seen_q;
    do_tok = 1'b0;
    ok     = 1'b0;
    t      = v6_q;
    if (acc && lit_i.kind) begin
      v4_d   = '0;
      v6_d   = '0;
      seen_d = 1'b0;
    end else if (acc) begin
      seen_d = 1'b1;
      if (!v6_q.failed) begin
        case (v6_q.phase)
          PH_START: begin
            if (c == ChColon) v6_d.phase = PH_LEAD;
            else do_tok = 1'b1;
          end
          PH_LEAD: begin
            if (c == ChColon) begin
              v6_d.run   = 1'b1;
              v6_d.phase = PH_AFTER_RUN;
            end else v6_d.failed = 1'b1;
          end
          PH_AFTER_RUN: begin
            if (c == ChColon) v6_d.failed = 1'b1;
            else do_tok = 1'b1;
          end
          PH_TOKEN: begin
            if (c == ChColon) begin
              t = v6_push(v6_q, tok_value(v6_q), ok);
              if (v6_q.tlen == 3'd0 || v6_q.tlen > 3'd4 || !ok) v6_d.failed = 1'b1;
              else begin
                v6_d       = t;
                v6_d.phase = PH_SEP;
              end
            end else begin
              do_tok = 1'b1;
            end
          end
          PH_QUAD: begin
            if (c == ChColon) v6_d.failed = 1'b1;
            else begin
              v4_d = v4_feed(v4_q, c);
              if (v4_d.failed) v6_d.failed = 1'b1;
            end
          end
          PH_SEP: begin
            if (c == ChColon) begin
              if (v6_q.run) v6_d.failed = 1'b1;
              else begin
                v6_d.run   = 1'b1;
                v6_d.phase = PH_AFTER_RUN;
              end
            end else do_tok = 1'b1;
          end
          default: v6_d.failed = 1'b1;
        endcase
        // A token that starts here begins empty.
        if (do_tok && v6_q.phase != PH_TOKEN) begin
          v6_d.tlen  = 3'd0;
          v6_d.phase = PH_TOKEN;
        end
        if (do_tok) begin
          if (c == ChDot) begin
            if (!v6_q.run && v6_q.hc == 4'd0 && v6_q.tc == 4'd0) v6_d.failed = 1'b1;
            else begin
              // Replay the token so far through the IPv4 parser.
              v4_d = '0;
              for (int i = 0; i < 4; i++) begin
                if (3'(i) < v6_d.tlen) v4_d = v4_feed(v4_d, v6_q.tok[i]);
              end
              v4_d       = v4_feed(v4_d, c);
              v6_d.phase = PH_QUAD;
              if (v4_d.failed) v6_d.failed = 1'b1;
            end
          end else if (is_hex(c)) begin
            if (v6_d.tlen >= 3'd4) v6_d.failed = 1'b1;
            else begin
              v6_d.tok[v6_d.tlen[1:0]] = c;
              v6_d.tlen = 3'(v6_d.tlen + 3'd1);
            end
          end else begin
            v6_d.failed = 1'b1;
          end
        end
      end
      if (v6_d.phase != PH_QUAD) v4_d = v4_feed(v4_q, c);
    end
  end

  // Completion of the literal at the end marker.
  always_comb begin
    v6_t  f;
    logic ok1, ok2;
    logic v6ok;
    f    = v6_q;
    ok1  = 1'b0;
    ok2  = 1'b0;
    v6ok = 1'b0;
    case (v6_q.phase)
      PH_AFTER_RUN: v6ok = v6_finish(v6_q);
      PH_TOKEN: begin
        f    = v6_push(v6_q, tok_value(v6_q), ok1);
        v6ok = v6_q.tlen != 3'd0 && v6_q.tlen <= 3'd4 && ok1 && v6_finish(f);
      end
      PH_QUAD: begin
        f    = v6_push(v6_q, {v4_q.octets[0], v4_q.octets[1]}, ok1);
        f    = v6_push(f, {v4_q.octets[2], v4_q.accum[7:0]}, ok2);
        v6ok = v4_done(v4_q) && ok1 && ok2 && v6_finish(f);
      end
      default: v6ok = 1'b0;
    endcase
    q_entry_o.v4_addr = {v4_q.octets[0], v4_q.octets[1], v4_q.octets[2], v4_q.accum[7:0]};
    q_entry_o.head    = f.head;
    q_entry_o.tail    = f.tail;
    q_entry_o.hc      = f.hc;
    q_entry_o.tc      = f.tc;
    if (seen_q && v6_q.phase != PH_QUAD && v4_done(v4_q)) q_entry_o.form = FORM_V4;
    else if (seen_q && !v6_q.failed && v6ok) q_entry_o.form = FORM_V6;
    else q_entry_o.form = FORM_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q   <= '0;
      v6_q   <= '0;
      seen_q <= 1'b0;
    end else begin
      v4_q   <= v4_d;
      v6_q   <= v6_d;
      seen_q <= seen_d;
    end
  end

endmodule

@@ sv/ilc_queue.sv @@
// ----------------------------------------------------------------------------
// ilc_queue
// Short queue of finished parses between the parser and the classifier.
// ----------------------------------------------------------------------------
module ilc_queue import ilc_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   ready_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign ready_o = cnt_q != CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign entry_o = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_q + 1'b1);
    if (do_pop) rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_q + 1'b1);
    if (do_push && !do_pop) cnt_d = CntW'(cnt_q + 1'b1);
    else if (do_pop && !do_push) cnt_d = CntW'(cnt_q - 1'b1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ sv/ilc_back.sv @@
// ----------------------------------------------------------------------------
// ilc_back
// Classifier: packs the address, classifies it and holds the result in the
// output register.
// ----------------------------------------------------------------------------
module ilc_back import ilc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     priv_fetch_i,
  input  logic     q_valid_i,
  input  entry_t   q_entry_i,
  output logic     q_pop_o,
  ilc_out_if.source res_o
);

  logic        valid_q;
  class_e      cls_q, cls_d;
  logic        fetch_q, fetch_d;
  form_e       form_q;
  logic [63:0] hi_q, hi_d, lo_q, lo_d;

  assign q_pop_o = q_valid_i && (!valid_q || res_o.ready);

  always_comb begin
    logic [7:0][15:0] g;
    logic [3:0]       start;
    start = 4'(4'd8 - q_entry_i.tc);
    // Tail groups sit flush right, head groups from the left.
    for (int p = 0; p < 8; p++) begin
      if (4'(p) >= start) g[7-p] = q_entry_i.tail[3'(4'(p) - start)];
      else if (4'(p) < q_entry_i.hc) g[7-p] = q_entry_i.head[p];
      else g[7-p] = 16'd0;
    end
    hi_d  = 64'd0;
    lo_d  = 64'd0;
    cls_d = CLS_UNKNOWN;
    case (q_entry_i.form)
      FORM_V4: begin
        lo_d  = {32'd0, q_entry_i.v4_addr};
        cls_d = classify_v4(q_entry_i.v4_addr[31:24], q_entry_i.v4_addr[23:16]);
      end
      FORM_V6: begin
        hi_d  = g[7:4];
        lo_d  = g[3:0];
        cls_d = classify_v6(g[7:4], g[3:0]);
      end
      default: cls_d = CLS_UNKNOWN;
    endcase
    case (cls_d)
      CLS_PUBLIC:  fetch_d = 1'b1;
      CLS_UNKNOWN: fetch_d = 1'b0;
      default:     fetch_d = priv_fetch_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cls_q   <= cls_d;
      fetch_q <= fetch_d;
      form_q  <= q_entry_i.form;
      hi_q    <= hi_d;
      lo_q    <= lo_d;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.addr_class   = cls_q;
  assign res_o.fetchable    = fetch_q;
  assign res_o.literal_form = form_q;
  assign res_o.addr_hi      = hi_q;
  assign res_o.addr_lo      = lo_q;

endmodule
